// ----- rtl/core/mavg_pkg.sv -----
// Package for the moving average / running min-max block.
// Shared widths, reset constants and the sequencer state type.
// No dependencies.
package mavg_pkg;

    localparam int SAMPLE_W         = 32;
    localparam int LEN_W            = 7;
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int WINDOW_LEN_RESET = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/mavg_ifs.sv -----
// Handshake interfaces of the moving average block: sample, result and config channels.
// Depends on mavg_pkg for field widths.
interface mavg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mavg_pkg::SAMPLE_W-1:0] sample;
    logic                                series_start;

    modport source (output valid, sample, series_start, input ready);
    modport sink   (input valid, sample, series_start, output ready);
endinterface

interface mavg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mavg_pkg::SAMPLE_W-1:0] average;
    logic                                average_valid;
    logic signed [mavg_pkg::SAMPLE_W-1:0] running_min;
    logic signed [mavg_pkg::SAMPLE_W-1:0] running_max;

    modport source (output valid, average, average_valid, running_min, running_max,
                    input ready);
    modport sink   (input valid, average, average_valid, running_min, running_max,
                    output ready);
endinterface

interface mavg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mavg_pkg::LEN_W-1:0]    window_len;

    modport source (output valid, window_len, input ready);
    modport sink   (input valid, window_len, output ready);
endinterface

// ----- rtl/core/mavg_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read (read-first).
// No dependencies.
module mavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // same-address read returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mavg_div.sv -----
// Bit-serial signed divider: signed dividend by unsigned divisor, quotient truncated to zero.
// One quotient bit per cycle. No dependencies.
module mavg_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7,
    parameter int QUOT_W     = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic signed [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;
    logic                  q_bit;
    logic [DIVISOR_W-1:0]  rem_next;
    logic                  last_step;
    logic [QUOT_W-1:0]     quot_mag;

    assign mag       = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
    assign rem_shift = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign diff      = rem_shift - {1'b0, div_reg};
    assign q_bit     = (rem_shift >= {1'b0, div_reg});
    assign rem_next  = q_bit ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    assign last_step = busy_reg && (cnt_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else
        begin
            done_reg <= last_step;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // numerator register shifts the quotient in from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIVIDEND_W-1];
            num_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIVIDEND_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign quot_mag = num_reg[QUOT_W-1:0];
    assign quotient = neg_reg ? -quot_mag : quot_mag;
    assign done     = done_reg;

endmodule

// ----- rtl/core/moving_average_min_max_top.sv -----
// Boxcar moving average with running min and max over a stream of signed Q16.16 samples.
// Depends on mavg_pkg, mavg_ifs, mavg_ram and mavg_div.
//
// Each item on the samples channel carries one sample and a series_start flag; each one
// gives exactly one item on the results channel. The last WINDOW_MAX samples live in a
// ring RAM; the running sum subtracts the sample that leaves the window (read from the
// RAM in the same cycle the new one is written) and adds the new one. Once window_len
// samples have arrived since the series began, the mean is the sum divided by
// window_len, truncated toward zero; before that average is 0 and average_valid is 0.
// running_min and running_max cover the whole series. A set series_start, or a write on
// the cfg channel, restarts the series. window_len 0 acts as 1, values above WINDOW_MAX
// act as WINDOW_MAX. Items are handled one at a time, through ST_IDLE, ST_SUM and ST_OUT
// while the window is filling, with ST_START and ST_DIV before ST_OUT once it is full; there
// the bit-serial divider yields one quotient bit per cycle. A finished result sits in an
// output register, so the next item is taken while it waits.
module moving_average_min_max_top #(
    parameter int WINDOW_MAX = mavg_pkg::WINDOW_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mavg_cfg_if.sink  cfg,
    mavg_in_if.sink   samples,
    mavg_out_if.source results
);

    localparam int SW      = mavg_pkg::SAMPLE_W;
    localparam int LW      = mavg_pkg::LEN_W;
    localparam int AW      = $clog2(WINDOW_MAX);
    // longest effective window: the register is 7 bits wide
    localparam int LEN_MAX = (WINDOW_MAX < (2 ** LW - 1)) ? WINDOW_MAX : (2 ** LW - 1);
    localparam int SUM_W   = SW + $clog2(LEN_MAX);
    localparam int IW      = ((AW > LW) ? AW : LW) + 1;
    localparam int LEN_RST = (mavg_pkg::WINDOW_LEN_RESET > LEN_MAX) ?
                             LEN_MAX : mavg_pkg::WINDOW_LEN_RESET;

    mavg_pkg::state_t state_reg, state_next;

    // series state
    logic [LW-1:0]           len_reg;
    logic [LW-1:0]           fill_reg;
    logic [AW-1:0]           ws_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SW-1:0]    min_reg;
    logic signed [SW-1:0]    max_reg;

    // item in flight
    logic signed [SUM_W-1:0] base_reg;
    logic                    drop_reg;
    logic                    avg_ok_reg;

    // result register
    logic                    res_valid_reg;
    logic signed [SW-1:0]    avg_out_reg;
    logic                    avgv_out_reg;
    logic signed [SW-1:0]    min_out_reg;
    logic signed [SW-1:0]    max_out_reg;

    logic                    accept;
    logic                    cfg_wr;
    logic                    res_load;
    logic                    div_start;
    logic                    div_done;
    logic signed [SW-1:0]    div_quot;

    logic [LW-1:0]           len_wr;
    logic                    restart;
    logic                    seed;
    logic [LW-1:0]           fill_eff;
    logic [LW-1:0]           fill_new;
    logic [IW-1:0]           ws_ext;
    logic [IW-1:0]           len_ext;
    logic [IW-1:0]           old_ext;
    logic [AW-1:0]           old_addr;
    logic [AW-1:0]           ws_inc;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] old_ext_val;
    logic signed [SUM_W-1:0] sum_new;
    logic [SW-1:0]           ram_rdata;

    // ---------------------------------------------------------------
    // Configuration: clamp once on write, restart the series
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        if (cfg.window_len == '0)
        begin
            len_wr = LW'(1);
        end
        else if (cfg.window_len > LW'(LEN_MAX))
        begin
            len_wr = LW'(LEN_MAX);
        end
        else
        begin
            len_wr = cfg.window_len;
        end
    end

    // ---------------------------------------------------------------
    // Accept-cycle arithmetic
    // ---------------------------------------------------------------
    assign restart    = samples.series_start;
    assign seed       = samples.series_start || (fill_reg == '0);
    assign fill_eff   = restart ? '0 : fill_reg;
    assign fill_new   = (fill_eff < len_reg) ? fill_eff + 1'b1 : fill_eff;
    assign sample_ext = {{(SUM_W - SW){samples.sample[SW-1]}}, samples.sample};

    // slot of the sample leaving the window, modulo the store depth
    assign ws_ext   = IW'(ws_reg);
    assign len_ext  = IW'(len_reg);
    assign old_ext  = (ws_ext >= len_ext) ? ws_ext - len_ext
                                          : ws_ext + IW'(WINDOW_MAX) - len_ext;
    assign old_addr = old_ext[AW-1:0];
    assign ws_inc   = (ws_reg == AW'(WINDOW_MAX - 1)) ? '0 : ws_reg + 1'b1;

    // ---------------------------------------------------------------
    // Ring store: read the leaving sample while writing the new one
    // ---------------------------------------------------------------
    mavg_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (ws_reg),
        .wdata (samples.sample),
        .raddr (old_addr),
        .rdata (ram_rdata)
    );

    assign old_ext_val = {{(SUM_W - SW){ram_rdata[SW-1]}}, ram_rdata};
    assign sum_new     = drop_reg ? base_reg - old_ext_val : base_reg;

    // ---------------------------------------------------------------
    // Mean: serial divider on the registered sum
    // ---------------------------------------------------------------
    mavg_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LW),
        .QUOT_W     (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = mavg_pkg::ST_SUM;
                end
            end
            mavg_pkg::ST_SUM:
            begin
                state_next = avg_ok_reg ? mavg_pkg::ST_START : mavg_pkg::ST_OUT;
            end
            mavg_pkg::ST_START:
            begin
                state_next = mavg_pkg::ST_DIV;
            end
            mavg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mavg_pkg::ST_OUT;
                end
            end
            mavg_pkg::ST_OUT:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    state_next = mavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = (state_reg == mavg_pkg::ST_IDLE);
        div_start     = (state_reg == mavg_pkg::ST_START);
        res_load      = (state_reg == mavg_pkg::ST_OUT) && (!res_valid_reg || results.ready);
    end

    assign accept = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mavg_pkg::ST_IDLE;
            len_reg       <= LW'(LEN_RST);
            fill_reg      <= '0;
            ws_reg        <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            avg_ok_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                fill_reg   <= fill_new;
                ws_reg     <= ws_inc;
                drop_reg   <= (fill_eff >= len_reg);
                avg_ok_reg <= (fill_new >= len_reg);
                if (seed || (samples.sample < min_reg))
                begin
                    min_reg <= samples.sample;
                end
                if (seed || (samples.sample > max_reg))
                begin
                    max_reg <= samples.sample;
                end
            end

            if (state_reg == mavg_pkg::ST_SUM)
            begin
                sum_reg <= sum_new;
            end

            // only to be written while idle: a rule for the user, the block itself does not enforce it
            if (cfg_wr)
            begin
                len_reg  <= len_wr;
                fill_reg <= '0;
                sum_reg  <= '0;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= (restart ? '0 : sum_reg) + sample_ext;
        end
        if (res_load)
        begin
            avg_out_reg  <= avg_ok_reg ? div_quot : '0;
            avgv_out_reg <= avg_ok_reg;
            min_out_reg  <= min_reg;
            max_out_reg  <= max_reg;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.average       = avg_out_reg;
    assign results.average_valid = avgv_out_reg;
    assign results.running_min   = min_out_reg;
    assign results.running_max   = max_out_reg;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for moving_average_min_max_top: boxcar mean plus running min/max.
// Depends on mavg_pkg, the mavg_*_if interfaces and the block itself; nothing else.
// Two drivers and a monitor run as clocked always blocks; an initial block queues items.
module tb_top;

    localparam int                   SAMPLE_W = mavg_pkg::SAMPLE_W;
    localparam int                   LEN_W    = mavg_pkg::LEN_W;
    localparam int                   WIN_CAP  = mavg_pkg::WINDOW_MAX_DEF;
    localparam logic signed [31:0]   S_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   S_MIN    = 32'sh8000_0000;

    // how the two ends of the data path idle in the current phase
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SNK_STALLS,
        FLOW_BOTH
    } flow_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       series_start;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       avg_ok;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } avg_result_t;

    logic clk;
    logic rst_n;

    mavg_cfg_if cfg_bus ();
    mavg_in_if  smp_bus ();
    mavg_out_if res_bus ();

    moving_average_min_max_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (smp_bus),
        .results (res_bus)
    );

    // ---------------------------------------------------------------------
    // Boxcar predictor: its own copy of the ring, sum, fill level and extremes
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] ring_mem [WIN_CAP];
    longint                     run_sum;
    int unsigned                fill_n;
    int unsigned                wr_ptr;
    logic signed [SAMPLE_W-1:0] lo_seen;
    logic signed [SAMPLE_W-1:0] hi_seen;
    logic [LEN_W-1:0]           win_len_reg;

    sample_item_t   pending_items [$];   // waiting for the driver
    avg_result_t    expected_avgs [$];   // predicted, not yet seen on the results channel

    flow_t          flow;
    int             hold_req;            // long receiver hold-off, picked up by the ready process
    int             hold_left;
    bit             sample_taken;        // set at the rising edge an item is accepted
    int             queued_cnt;
    int             accepted_cnt;
    int             cfg_writes;
    int             fail_cnt;

    function automatic int unsigned span_of(input logic [LEN_W-1:0] len);
        if (len == '0)
            return 1;
        if (32'(len) > WIN_CAP)
            return WIN_CAP;
        return 32'(len);
    endfunction

    function automatic avg_result_t boxcar_step(input logic signed [SAMPLE_W-1:0] s,
                                                input logic start);
        avg_result_t r;
        int unsigned span;
        int unsigned old_slot;
        span = span_of(win_len_reg);
        if (start)
        begin
            run_sum = 0;
            fill_n  = 0;
        end
        // a fresh series (or the very first sample) seeds both extremes
        if (start || fill_n == 0)
        begin
            lo_seen = s;
            hi_seen = s;
        end
        else
        begin
            if (s < lo_seen)
                lo_seen = s;
            if (s > hi_seen)
                hi_seen = s;
        end
        // full window: the oldest sample leaves before the new one joins
        if (fill_n >= span)
        begin
            old_slot = (wr_ptr + WIN_CAP - span) % WIN_CAP;
            run_sum -= longint'(ring_mem[old_slot]);
        end
        ring_mem[wr_ptr] = s;
        run_sum += longint'(s);
        wr_ptr = (wr_ptr + 1) % WIN_CAP;
        if (fill_n < span)
            fill_n++;
        r.avg_ok  = (fill_n >= span);
        // signed division truncates toward zero, as the block must
        r.average = r.avg_ok ? SAMPLE_W'(run_sum / longint'(span)) : '0;
        r.lo      = lo_seen;
        r.hi      = hi_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Clock and time limit
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous cap, many times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Driver: samples channel, changes on the falling edge
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : sample_drv
        sample_item_t nxt;
        bit           gap;
        if (!rst_n)
            smp_bus.valid <= 1'b0;
        else if (!smp_bus.valid || sample_taken)
        begin
            case (flow)
                FLOW_SRC_GAPS: gap = ($urandom_range(0, 99) < 62);
                FLOW_BOTH:     gap = ($urandom_range(0, 99) < 10);
                default:       gap = 1'b0;
            endcase
            if (pending_items.size() != 0 && !gap)
            begin
                nxt = pending_items.pop_front();
                smp_bus.valid        <= 1'b1;
                smp_bus.sample       <= nxt.sample;
                smp_bus.series_start <= nxt.series_start;
            end
            else
                smp_bus.valid <= 1'b0;
        end
    end

    // Results ready, with random stalls and the occasional long hold-off
    always @(negedge clk)
    begin : ready_drv
        bit stall;
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        case (flow)
            FLOW_SNK_STALLS: stall = ($urandom_range(0, 99) < 62);
            FLOW_BOTH:       stall = ($urandom_range(0, 99) < 10);
            default:         stall = 1'b0;
        endcase
        if (hold_left != 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= !stall;
    end

    // ---------------------------------------------------------------------
    // Monitor: all three channels sampled on the rising edge.
    // Results are checked before this edge's item is predicted.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        avg_result_t want;
        sample_taken = rst_n && smp_bus.valid && smp_bus.ready;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_avgs.size() == 0)
                begin
                    $error("result item with nothing expected: average %0d min %0d max %0d",
                           res_bus.average, res_bus.running_min, res_bus.running_max);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_avgs.pop_front();
                    if (res_bus.average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average, res_bus.average);
                        fail_cnt++;
                    end
                    if (res_bus.average_valid !== want.avg_ok)
                    begin
                        $error("average_valid: expected %0d, got %0d",
                               want.avg_ok, res_bus.average_valid);
                        fail_cnt++;
                    end
                    if (res_bus.running_min !== want.lo)
                    begin
                        $error("running_min: expected %0d, got %0d", want.lo, res_bus.running_min);
                        fail_cnt++;
                    end
                    if (res_bus.running_max !== want.hi)
                    begin
                        $error("running_max: expected %0d, got %0d", want.hi, res_bus.running_max);
                        fail_cnt++;
                    end
                end
            end
            // a length write restarts the series
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                win_len_reg = cfg_bus.window_len;
                run_sum     = 0;
                fill_n      = 0;
                cfg_writes++;
            end
            if (sample_taken)
            begin
                expected_avgs.push_back(boxcar_step(smp_bus.sample, smp_bus.series_start));
                accepted_cnt++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic st);
        sample_item_t it;
        it.sample       = s;
        it.series_start = st;
        pending_items.push_back(it);
        queued_cnt++;
    endtask

    // wait until every queued item is in and every result has come out
    task automatic drain();
        while (accepted_cnt != queued_cnt || expected_avgs.size() != 0)
            @(negedge clk);
    endtask

    // length writes only with the block idle
    task automatic write_window(input logic [LEN_W-1:0] len);
        int seen;
        drain();
        seen = cfg_writes;
        @(negedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.window_len <= len;
        while (cfg_writes == seen)
            @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random phase: one length, one idling pattern. Series starts are rare enough
    // that most series fill their window; samples mix extremes, small and full-range.
    task automatic run_phase(input logic [LEN_W-1:0] len, input flow_t fl, input int n,
                             input bit pause_mid, input int hold);
        int unsigned                span;
        logic signed [SAMPLE_W-1:0] s;
        logic                       st;
        write_window(len);
        @(posedge clk);
        flow = fl;
        span = span_of(len);
        for (int i = 0; i < n; i++)
        begin
            // sender stops until the block has emptied, then carries on
            if (pause_mid && i == n / 2)
            begin
                drain();
                @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0:       s = S_MAX;
                1:       s = S_MIN;
                2, 3, 4: s = $signed($urandom_range(0, 2000)) - 1000;
                default: s = $urandom;
            endcase
            st = ($urandom_range(0, 4 * span + 3) == 0);
            push_item(s, st);
        end
        // receiver holds off while the sender keeps offering; the block backs up
        if (hold != 0)
            hold_req = hold;
        drain();
    endtask

    initial
    begin
        // predictor state after reset
        run_sum     = 0;
        fill_n      = 0;
        wr_ptr      = 0;
        lo_seen     = '0;
        hi_seen     = '0;
        win_len_reg = LEN_W'(mavg_pkg::WINDOW_LEN_RESET);
        flow        = FLOW_FREE;
        hold_req    = 0;
        hold_left   = 0;
        sample_taken = 1'b0;
        queued_cnt   = 0;
        accepted_cnt = 0;
        cfg_writes   = 0;
        fail_cnt     = 0;

        // every input known from time zero
        cfg_bus.valid        = 1'b0;
        cfg_bus.window_len   = '0;
        smp_bus.valid        = 1'b0;
        smp_bus.sample       = '0;
        smp_bus.series_start = 1'b0;
        res_bus.ready        = 1'b0;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset length 15: first sample after reset seeds min/max without
        // a start flag, extremes, then a series start while the window is still filling
        @(posedge clk);
        push_item(S_MAX, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(32'sd0, 1'b0);
        push_item(-32'sd1, 1'b0);
        push_item(32'sd1, 1'b1);

        // length 0 acts as 1: the mean is the sample itself
        write_window(7'd0);
        @(posedge clk);
        push_item(S_MAX, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(-32'sd1, 1'b0);
        push_item(32'sd1, 1'b1);
        push_item(-32'sh0001_0000, 1'b0);

        // length 2: truncation toward zero on negative sums, extreme sums
        write_window(7'd2);
        @(posedge clk);
        push_item(-32'sd1, 1'b0);
        push_item(-32'sd2, 1'b0);
        push_item(S_MAX, 1'b0);
        push_item(S_MAX, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(32'sd3, 1'b1);
        push_item(-32'sd6, 1'b0);

        // random phases; lengths above the store size act as the store size
        run_phase(7'd1,   FLOW_FREE,       150, 1'b0, 0);
        run_phase(7'd64,  FLOW_SRC_GAPS,   250, 1'b0, 0);
        run_phase(7'd127, FLOW_SNK_STALLS, 250, 1'b0, 0);
        run_phase(7'd15,  FLOW_BOTH,       200, 1'b0, 0);
        run_phase(LEN_W'($urandom_range(2, 63)), FLOW_FREE, 250, 1'b0, 300);
        run_phase(7'd3,   FLOW_SRC_GAPS,   200, 1'b1, 0);
        run_phase(LEN_W'($urandom_range(0, 127)), FLOW_BOTH, 200, 1'b0, 0);
        run_phase(7'd0,   FLOW_SNK_STALLS, 150, 1'b0, 0);
        run_phase(7'd64,  FLOW_FREE,       200, 1'b0, 0);

        // tail: anything arriving now is unexpected
        drain();
        repeat (60) @(negedge clk);
        if (expected_avgs.size() != 0)
        begin
            $error("%0d result items never arrived", expected_avgs.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
